/* rtl/core/spq_pkg.sv */
`default_nettype none

package spq_pkg;

    localparam int OP_W  = 2;
    localparam int PRI_W = 16;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [ST_W-1:0] ST_SUCCESS  = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

endpackage

`default_nettype wire

/* rtl/core/sorted_priority_queue.sv */
`default_nettype none

// Channel   Direction  Handshake                   Payload
// request   in         i_in_valid / o_in_stall     i_opcode, i_priority_req, i_value
// result    out        o_out_valid / i_out_stall   o_status, o_popped_value, o_length
//
// A push reads the held entries from the tail toward the head; each one of lower
// priority moves one slot back through the entry memory, and the new entry is
// written into the freed slot. A pop takes the head from a registered memory read.
// Clear, overflow, empty and the unused opcode go straight to the result state.
// Reset is synchronous and active low; it empties the queue, entry data is kept.
// A stalled result waits in the output register while the next request is taken.

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [OP_W-1:0]         i_opcode,
    input  wire logic [PRI_W-1:0]        i_priority_req,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [ST_W-1:0]              o_status,
    output logic signed [VAL_W-1:0]      o_popped_value,
    output logic [LEN_W-1:0]             o_length
);

    localparam int SW = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = PRI_W + SW;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PSCAN = 2'd1;
    localparam logic [1:0] S_POPD  = 2'd2;
    localparam logic [1:0] S_RES   = 2'd3;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] j);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, j};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [EW-1:0]    r_mem [DEPTH];
    logic [EW-1:0]    r_rd;
    logic [1:0]       r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_k, n_k;
    logic [PRI_W-1:0] r_pri, n_pri;
    logic [SW-1:0]    r_val, n_val;
    logic [ST_W-1:0]  r_st, n_st;
    logic [SW-1:0]    r_pop, n_pop;
    logic             r_out_valid;
    logic [ST_W-1:0]  r_out_status;
    logic [VAL_W-1:0] r_out_popped;
    logic [LEN_W-1:0] r_out_length;

    logic                accept;
    logic                out_free;
    logic [CW-1:0]       rd_j;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;
    logic [PRI_W-1:0]    rd_pri;
    logic [SW-1:0]       rd_val;
    logic [CW+LEN_W-1:0] cnt_ext;
    logic [SW+VAL_W-1:0] pop_ext;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_pri   = r_rd[EW-1:SW];
    assign rd_val   = r_rd[SW-1:0];
    assign rd_addr  = f_phys(r_head, rd_j[AW-1:0]);
    assign cnt_ext  = {{LEN_W{1'b0}}, r_count};
    assign pop_ext  = {{VAL_W{1'b0}}, r_pop};

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        n_k     = r_k;
        n_pri   = r_pri;
        n_val   = r_val;
        n_st    = r_st;
        n_pop   = r_pop;
        rd_j    = '0;
        wr_en   = 1'b0;
        wr_addr = f_phys(r_head, r_k[AW-1:0]);
        wr_data = {r_pri, r_val};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pri = i_priority_req;
                    n_val = i_value[SW-1:0];
                    n_st  = ST_SUCCESS;
                    n_pop = '0;
                    case (i_opcode)
                        OP_PUSH: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_st    = ST_OVERFLOW;
                                n_state = S_RES;
                            end else begin
                                n_k     = r_count;
                                n_state = S_PSCAN;
                                if (r_count != '0) begin
                                    rd_j = r_count - CW'(1);
                                end
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_st    = ST_EMPTY;
                                n_state = S_RES;
                            end else begin
                                n_state = S_POPD;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_RES;
                        end
                        default: begin
                            n_state = S_RES;
                        end
                    endcase
                end
            end
            S_PSCAN: begin
                wr_en = 1'b1;
                if (r_k == '0 || rd_pri >= r_pri) begin
                    n_count = r_count + CW'(1);
                    n_state = S_RES;
                end else begin
                    wr_data = r_rd;
                    n_k     = r_k - CW'(1);
                    if (n_k != '0) begin
                        rd_j = n_k - CW'(1);
                    end
                end
            end
            S_POPD: begin
                n_pop   = rd_val;
                n_count = r_count - CW'(1);
                if (r_head == AW'(DEPTH - 1)) begin
                    n_head = '0;
                end else begin
                    n_head = r_head + AW'(1);
                end
                n_state = S_RES;
            end
            S_RES: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (r_state == S_RES && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_pri <= n_pri;
        r_val <= n_val;
        r_st  <= n_st;
        r_pop <= n_pop;
        if (r_state == S_RES && out_free) begin
            r_out_status <= r_st;
            r_out_popped <= pop_ext[VAL_W-1:0];
            r_out_length <= cnt_ext[LEN_W-1:0];
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_popped_value = r_out_popped;
    assign o_length       = r_out_length;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_hole_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PSCAN) |-> (r_k <= r_count && r_count < CW'(DEPTH)))
        else $error("Insertion position lies outside the held entries.");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POPD) |-> (r_count != '0))
        else $error("Pop read started on an empty queue.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RES))
        else $error("Result presented without a finished operation.");

endmodule

`default_nettype wire
